[hw/rtl/csort_pkg.sv]
// Shared types, sizes and the gap shrink table for the comb sort engine.
// No dependencies; every other file refers to it by scoped names.
package csort_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_ELEMS  = 64;
  localparam int ADDR_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W      = $clog2(MAX_ELEMS + 1);

  // Shrink factor 1.247 as an exact ratio.
  localparam int SHRINK_NUM = 1000;
  localparam int SHRINK_DEN = 1247;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef cnt_t                  gap_tbl_t [0:MAX_ELEMS];

  function automatic gap_tbl_t build_gap_tbl();
    gap_tbl_t t;
    for (int i = 0; i <= MAX_ELEMS; i++) begin
      t[i] = CNT_W'((i * SHRINK_NUM) / SHRINK_DEN);
    end
    return t;
  endfunction

  // floor(g * 1000 / 1247) for every gap the engine can hold.
  localparam gap_tbl_t GAP_SHRINK = build_gap_tbl();

  // Request from the sequencer to the element store.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  wr_en;
    addr_t wr_addr;
    data_t wr_data;
  } ram_req_t;

  // Registered read data from the element store.
  typedef struct packed {
    data_t rd_a;
    data_t rd_b;
  } ram_rsp_t;

endpackage

[hw/rtl/csort_ram.sv]
// Element store: one write port, two read ports, read data registered.
// Depends on csort_pkg for sizes and the request/response structs.
module csort_ram (
  input  logic               clk,
  input  csort_pkg::ram_req_t req,
  output csort_pkg::ram_rsp_t rsp
);

  csort_pkg::data_t mem [0:csort_pkg::MAX_ELEMS-1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rsp.rd_a <= mem[req.rd_addr_a];
      rsp.rd_b <= mem[req.rd_addr_b];
    end
  end

endmodule

[hw/rtl/csort_ctrl.sv]
// Sequencer: loads the set, runs comb sort passes through the store, emits results.
// Depends on csort_pkg; drives csort_ram through ram_req_t / ram_rsp_t.
module csort_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  csort_pkg::data_t    s_tdata,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output csort_pkg::data_t    m_tdata,
  output logic                m_tlast,
  output csort_pkg::ram_req_t req,
  input  csort_pkg::ram_rsp_t rsp
);

  typedef enum logic [2:0] {
    ST_LOAD, ST_CHK, ST_CMP, ST_WRA, ST_WRB, ST_ERD, ST_ELD, ST_EOUT
  } state_t;

  state_t          state;
  csort_pkg::cnt_t count;
  csort_pkg::cnt_t gap;
  csort_pkg::cnt_t pidx;
  logic            swapped;

  logic [csort_pkg::CNT_W:0] pair_b;
  logic                      in_pass;
  logic                      has_room;
  csort_pkg::cnt_t           count_next;
  csort_pkg::cnt_t           first_gap;
  csort_pkg::cnt_t           gap_next;

  function automatic csort_pkg::cnt_t shrink(csort_pkg::cnt_t g);
    csort_pkg::cnt_t s;
    s = csort_pkg::GAP_SHRINK[g];
    return (s == '0) ? csort_pkg::CNT_W'(1) : s;
  endfunction

  always_comb begin
    pair_b     = {1'b0, pidx} + {1'b0, gap};
    in_pass    = pair_b < {1'b0, count};
    has_room   = count < csort_pkg::CNT_W'(csort_pkg::MAX_ELEMS);
    count_next = has_room ? count + csort_pkg::CNT_W'(1) : count;
    first_gap  = shrink(count_next);
    gap_next   = shrink(gap);
  end

  assign s_tready = (state == ST_LOAD);

  always_comb begin
    req.rd_en     = ((state == ST_CHK) && in_pass) || (state == ST_ERD);
    req.rd_addr_a = pidx[csort_pkg::ADDR_W-1:0];
    req.rd_addr_b = pair_b[csort_pkg::ADDR_W-1:0];
    req.wr_en     = 1'b0;
    req.wr_addr   = count[csort_pkg::ADDR_W-1:0];
    req.wr_data   = s_tdata;
    unique case (state)
      ST_LOAD: req.wr_en = s_tvalid && has_room;
      ST_WRA: begin
        req.wr_en   = 1'b1;
        req.wr_addr = pidx[csort_pkg::ADDR_W-1:0];
        req.wr_data = rsp.rd_b;
      end
      ST_WRB: begin
        req.wr_en   = 1'b1;
        req.wr_addr = pair_b[csort_pkg::ADDR_W-1:0];
        req.wr_data = rsp.rd_a;
      end
      default: req.wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      gap      <= '0;
      pidx     <= '0;
      swapped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            count <= count_next;
            if (s_tlast) begin
              gap     <= first_gap;
              pidx    <= '0;
              swapped <= 1'b0;
              state   <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          if (in_pass) begin
            state <= ST_CMP;
          end else if ((gap == csort_pkg::CNT_W'(1)) && !swapped) begin
            pidx  <= '0;
            state <= ST_ERD;
          end else begin
            gap     <= gap_next;
            pidx    <= '0;
            swapped <= 1'b0;
          end
        end
        ST_CMP: begin
          if ($signed(rsp.rd_a) > $signed(rsp.rd_b)) begin
            state <= ST_WRA;
          end else begin
            pidx  <= pidx + csort_pkg::CNT_W'(1);
            state <= ST_CHK;
          end
        end
        ST_WRA: state <= ST_WRB;
        ST_WRB: begin
          swapped <= 1'b1;
          pidx    <= pidx + csort_pkg::CNT_W'(1);
          state   <= ST_CHK;
        end
        ST_ERD: state <= ST_ELD;
        ST_ELD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= rsp.rd_a;
          m_tlast  <= (pidx + csort_pkg::CNT_W'(1)) == count;
          state    <= ST_EOUT;
        end
        ST_EOUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              pidx  <= pidx + csort_pkg::CNT_W'(1);
              state <= ST_ERD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

[hw/rtl/comb_sort_engine_core.sv]
// Top level of the comb sort engine: element store plus sequencer.
// Depends on csort_pkg, csort_ram and csort_ctrl.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata = value, s_tlast = last
//  m_*       out  m_tvalid / m_tready  m_tdata = sorted_value, m_tlast = end_of_set
//
// Loading takes one request per cycle until the request marked last.
// Sorting then runs through the single write port of the store: a compare
// passes through ST_CHK and ST_CMP, a swap adds ST_WRA and ST_WRB, and each pass ends in ST_CHK.
// Emission steps through ST_ERD, ST_ELD and ST_EOUT per result, waiting on m_tready; s_tready
// stays low from the last request until the final result is taken.
// Reset (rst, synchronous) clears control state only; the store is not cleared.
module comb_sort_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast    // end_of_set
);

  csort_pkg::ram_req_t ram_req;
  csort_pkg::ram_rsp_t ram_rsp;

  // Hold the set, which is sorted in place during the passes.
  csort_ram u_ram (
    .clk (clk),
    .req (ram_req),
    .rsp (ram_rsp)
  );

  // Advance load, sort passes and emission.
  csort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .req      (ram_req),
    .rsp      (ram_rsp)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for comb_sort_engine_core: streams sets of signed values in,
// predicts the ascending comb-sorted output and checks every emitted result.
// Depends on csort_pkg and the RTL of the engine only.
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;

  // One load request and one expected sorted result.
  typedef struct {
    csort_pkg::data_t value;
    logic             last;
  } load_req_t;

  typedef struct {
    csort_pkg::data_t value;
    logic             end_of_set;
  } sorted_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;

  load_req_t   pending_reqs[$];
  sorted_res_t expected_sorted[$];

  // Predictor state: the set being loaded.
  csort_pkg::data_t sort_store [csort_pkg::MAX_ELEMS];
  int               sort_count;

  int error_count;
  int cycle_count;
  int sender_idle_pct;
  int recv_stall_pct;

  comb_sort_engine_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    sort_count  = 0;
    error_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  end

  // Sort the loaded set in place the way the engine does, then queue every
  // element as an expected result and start an empty set.
  function automatic void sort_and_emit();
    int               gap;
    bit               swapped;
    csort_pkg::data_t t;
    gap = (sort_count * csort_pkg::SHRINK_NUM) / csort_pkg::SHRINK_DEN;
    forever begin
      if (gap < 1) gap = 1;
      swapped = 1'b0;
      for (int i = 0; i + gap < sort_count; i++) begin
        if ($signed(sort_store[i]) > $signed(sort_store[i + gap])) begin
          t                  = sort_store[i];
          sort_store[i]      = sort_store[i + gap];
          sort_store[i + gap] = t;
          swapped            = 1'b1;
        end
      end
      if (gap == 1 && !swapped) break;
      gap = (gap * csort_pkg::SHRINK_NUM) / csort_pkg::SHRINK_DEN;
    end
    for (int k = 0; k < sort_count; k++) begin
      expected_sorted.push_back('{value: sort_store[k], end_of_set: (k == sort_count - 1)});
    end
    sort_count = 0;
  endfunction

  // Fold one accepted request into the predictor. A full store drops the
  // value, but a request marked last still starts the sort.
  function automatic void load_element(csort_pkg::data_t value, logic last);
    if (sort_count < csort_pkg::MAX_ELEMS) begin
      sort_store[sort_count] = value;
      sort_count++;
    end
    if (last) sort_and_emit();
  endfunction

  // Driver: account for the request taken at this edge, then present the
  // next one unless the sender idles this cycle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        load_element(s_tdata, s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_reqs[0].value;
          s_tlast  <= pending_reqs[0].last;
          void'(pending_reqs.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest expectation, then
  // pick the ready level for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_sorted.size() == 0) begin
          $error("unexpected result: sorted_value %0d end_of_set %0b",
                 $signed(m_tdata), m_tlast);
          error_count++;
        end else begin
          if (m_tdata !== expected_sorted[0].value) begin
            $error("sorted_value: expected %0d, got %0d",
                   $signed(expected_sorted[0].value), $signed(m_tdata));
            error_count++;
          end
          if (m_tlast !== expected_sorted[0].end_of_set) begin
            $error("end_of_set: expected %0b, got %0b",
                   expected_sorted[0].end_of_set, m_tlast);
            error_count++;
          end
          void'(expected_sorted.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("comb_sort_engine_core regression: fail");
      $finish;
    end
  end

  function automatic void push_req(csort_pkg::data_t value, logic last);
    pending_reqs.push_back('{value: value, last: last});
  endfunction

  // Random value: full range, a narrow band full of duplicates, or extremes.
  function automatic csort_pkg::data_t pick_value(int style);
    csort_pkg::data_t v;
    case (style)
      0: v = $urandom;
      1: v = csort_pkg::data_t'($urandom_range(6)) - csort_pkg::data_t'(3);
      default: begin
        case ($urandom_range(4))
          0: v = {1'b1, {(csort_pkg::DATA_WIDTH-1){1'b0}}};
          1: v = {1'b0, {(csort_pkg::DATA_WIDTH-1){1'b1}}};
          2: v = '0;
          3: v = '1;
          default: v = csort_pkg::data_t'(1);
        endcase
      end
    endcase
    return v;
  endfunction

  // Queue a set of n requests, the final one marked last.
  function automatic int push_set(int n);
    int style;
    style = $urandom_range(99) < 60 ? 0 : $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      push_req(pick_value(style), i == n - 1);
    end
    return n;
  endfunction

  // Hold until every request is taken and every result has come back.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_sorted.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    int sent;
    idle_mix  = '{0, 69, 0, 31};
    stall_mix = '{0, 0, 69, 31};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets: lone minimum, lone maximum, a reversed pair of the
    // extremes, duplicates with sign changes, an already ascending run, a descending run.
    push_req({1'b1, {(csort_pkg::DATA_WIDTH-1){1'b0}}}, 1'b1);
    push_req({1'b0, {(csort_pkg::DATA_WIDTH-1){1'b1}}}, 1'b1);
    push_req({1'b0, {(csort_pkg::DATA_WIDTH-1){1'b1}}}, 1'b0);
    push_req({1'b1, {(csort_pkg::DATA_WIDTH-1){1'b0}}}, 1'b1);
    push_req(csort_pkg::data_t'(0), 1'b0);
    push_req('1, 1'b0);
    push_req(csort_pkg::data_t'(1), 1'b0);
    push_req({1'b1, {(csort_pkg::DATA_WIDTH-1){1'b0}}}, 1'b0);
    push_req({1'b0, {(csort_pkg::DATA_WIDTH-1){1'b1}}}, 1'b0);
    push_req('1, 1'b0);
    push_req(csort_pkg::data_t'(0), 1'b1);
    for (int i = 0; i < 5; i++) push_req(csort_pkg::data_t'(i * 7 - 10), i == 4);
    for (int i = 0; i < 5; i++) push_req(csort_pkg::data_t'(40 - i * 9), i == 4);
    wait_drained();

    // Random phases, each with its own idle and stall mix. The last one also
    // overfills the store so that trailing values, the last one too, drop.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_mix[ph];
      recv_stall_pct  = stall_mix[ph];
      sent = 0;
      if (ph == 3) begin
        for (int i = 0; i < csort_pkg::MAX_ELEMS; i++) push_req($urandom, 1'b0);
        for (int i = $urandom_range(1, 3); i > 0; i--) push_req($urandom, i == 1);
      end
      while (sent < 4) begin
        sent += push_set($urandom_range(99) < 15 ? 1 : $urandom_range(2, 10));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_sorted.size() == 0) begin
      $display("comb_sort_engine_core regression: pass");
    end else begin
      $display("comb_sort_engine_core regression: fail");
    end
    $finish;
  end

endmodule
